// File: rtl/gabor_patch_adder_unit_defines.svh
// Assertion macros for the Gabor patch adder.
// Included by files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef GABOR_PATCH_ADDER_UNIT_DEFINES_SVH
`define GABOR_PATCH_ADDER_UNIT_DEFINES_SVH

// same-cycle implication
`define GPA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gpa_pkg.sv
// Shared types, constants and helpers for the Gabor patch adder.
// No dependencies.
package gpa_pkg;

  localparam int unsigned MAX_COLS   = 4096;
  localparam int unsigned MAX_ROWS   = 4096;
  localparam int unsigned NUM_STAGES = 25;

  localparam int unsigned DX_W = 21;
  localparam int unsigned E_W  = 29;
  localparam int unsigned G_W  = 31;

  localparam logic [E_W-1:0]  E_LIMIT  = E_W'(24 << 24);
  localparam logic [22:0]     HI_LIMIT = 23'(24 << 16);
  localparam logic [30:0]     ONE_Q30  = 31'(1 << 30);
  localparam logic [32:0]     TWO_PI_Q30 = 33'd6746518852;

  localparam longint unsigned Q30_SCALE = 64'd1073741824;
  localparam longint unsigned PPB_ONE   = 64'd1000000000;
  localparam longint unsigned PPB_HALF  = 64'd500000000;

  // cos(k*pi/32), k = 0..16, Q1.30
  localparam logic [30:0] COS_TAB [17] = '{
    31'((64'd1000000000 * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd995184727  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd980785280  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd956940336  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd923879533  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd881921264  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd831469612  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd773010453  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd707106781  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd634393284  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd555570233  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd471396737  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd382683432  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd290284677  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd195090322  * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'((64'd98017140   * Q30_SCALE + PPB_HALF) / PPB_ONE),
    31'd0
  };

  typedef enum logic [2:0] {
    CFG_X_CENTER    = 3'd0,
    CFG_Y_CENTER    = 3'd1,
    CFG_X_STEP      = 3'd2,
    CFG_Y_STEP      = 3'd3,
    CFG_X_SPREAD    = 3'd4,
    CFG_Y_SPREAD    = 3'd5,
    CFG_PHASE_OFS   = 3'd6,
    CFG_AMPLITUDE   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [19:0] x_center;
    logic signed [19:0] y_center;
    logic signed [23:0] x_phase_step;
    logic signed [23:0] y_phase_step;
    logic        [31:0] x_spread_coeff;
    logic        [31:0] y_spread_coeff;
    logic        [23:0] phase_offset;
    logic signed [31:0] amplitude;
  } cfg_t;

  // floor(x/6) for x < 2^17: reciprocal multiply, one correction step
  function automatic logic [16:0] div6(input logic [16:0] x);
    logic [33:0] p;
    logic [16:0] q;
    logic [19:0] r;
    p = 34'(x) * 34'd43690;
    q = 17'(p[33:18]);
    r = 20'(x) - 20'(q) * 20'd6;
    if (r >= 20'd6) q = q + 17'd1;
    return q;
  endfunction

  // floor(x/24) for x < 2^13
  function automatic logic [12:0] div24(input logic [12:0] x);
    logic [26:0] p;
    logic [12:0] q;
    logic [15:0] r;
    p = 27'(x) * 27'd682;
    q = p[26:14];
    r = 16'(x) - 16'(q) * 16'd24;
    if (r >= 16'd24) q = q + 13'd1;
    return q;
  endfunction

endpackage

// File: rtl/gpa_geom.sv
// Offsets, squares, phase sum and Gaussian exponent terms (stages 1 to 4).
// Uses gpa_pkg.
module gpa_geom #(
  parameter int unsigned MaxCols = gpa_pkg::MAX_COLS,
  parameter int unsigned MaxRows = gpa_pkg::MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic [gpa_pkg::NUM_STAGES:1]       en_i,
  input  gpa_pkg::cfg_t                      cfg_i,
  input  logic [11:0]                        col_i,
  input  logic [11:0]                        row_i,
  output logic [gpa_pkg::E_W-1:0]            ex_o,
  output logic [gpa_pkg::E_W-1:0]            ey_o,
  output logic [23:0]                        phase_o
);

  localparam logic [16:0] ColLast = 17'(MaxCols - 1);
  localparam logic [16:0] RowLast = 17'(MaxRows - 1);

  function automatic logic [gpa_pkg::E_W-1:0] expo(input logic [54:0] hi, input logic [54:0] lo);
    logic [47:0] s;
    if (hi >= 55'(gpa_pkg::HI_LIMIT)) return gpa_pkg::E_LIMIT;
    s = 48'({hi[20:0], 8'b0}) + 48'(lo[54:8]);
    if (s > 48'(gpa_pkg::E_LIMIT)) return gpa_pkg::E_LIMIT;
    return s[gpa_pkg::E_W-1:0];
  endfunction

  logic [11:0] colc, rowc;
  logic signed [gpa_pkg::DX_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [41:0] dxx, dyy;
  logic signed [44:0] pxp, pyp;
  logic [38:0] dx2_q, dy2_q;
  logic [27:0] px_q, py_q, ph_sum;
  logic [54:0] hx_d, lx_d, hy_d, ly_d, hx_q, lx_q, hy_q, ly_q;
  logic [23:0] phase_q;
  logic [gpa_pkg::E_W-1:0] ex_q, ey_q;

  // stage 1
  assign colc = ({5'b0, col_i} > ColLast) ? ColLast[11:0] : col_i;
  assign rowc = ({5'b0, row_i} > RowLast) ? RowLast[11:0] : row_i;
  assign dx_d = gpa_pkg::DX_W'($signed({1'b0, colc, 4'b0})) - gpa_pkg::DX_W'(cfg_i.x_center);
  assign dy_d = gpa_pkg::DX_W'($signed({1'b0, rowc, 4'b0})) - gpa_pkg::DX_W'(cfg_i.y_center);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // stage 2
  assign dxx = dx_q * dx_q;
  assign dyy = dy_q * dy_q;
  assign pxp = 45'(cfg_i.x_phase_step) * 45'(dx_q);
  assign pyp = 45'(cfg_i.y_phase_step) * 45'(dy_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dx2_q <= dxx[38:0];
      dy2_q <= dyy[38:0];
      px_q  <= pxp[27:0];
      py_q  <= pyp[27:0];
    end
  end

  // stage 3
  assign hx_d = 55'(cfg_i.x_spread_coeff[31:16]) * 55'(dx2_q);
  assign lx_d = 55'(cfg_i.x_spread_coeff[15:0])  * 55'(dx2_q);
  assign hy_d = 55'(cfg_i.y_spread_coeff[31:16]) * 55'(dy2_q);
  assign ly_d = 55'(cfg_i.y_spread_coeff[15:0])  * 55'(dy2_q);
  assign ph_sum = {cfg_i.phase_offset, 4'b0} + px_q + py_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      hx_q    <= hx_d;
      lx_q    <= lx_d;
      hy_q    <= hy_d;
      ly_q    <= ly_d;
      phase_q <= ph_sum[27:4];
    end
  end

  // stage 4
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      ex_q <= expo(hx_q, lx_q);
      ey_q <= expo(hy_q, ly_q);
    end
  end

  assign ex_o    = ex_q;
  assign ey_o    = ey_q;
  assign phase_o = phase_q;

endmodule

// File: rtl/gpa_env.sv
// Gaussian envelope: series start then 13 squaring stages (stages 5 to 22).
// Uses gpa_pkg.
module gpa_env (
  input  logic                         clk_i,
  input  logic [gpa_pkg::NUM_STAGES:1] en_i,
  input  logic [gpa_pkg::E_W-1:0]      ex_i,
  input  logic [gpa_pkg::E_W-1:0]      ey_i,
  output logic [gpa_pkg::G_W-1:0]      g_o
);

  logic [29:0] esum;
  logic [21:0] a5_q, a6_q, a7_q, a8_q;
  logic        big5_q, big6_q, big7_q, big8_q;
  logic [43:0] aa_d, aa6_q;
  logic [35:0] a2a_d, a2a7_q;
  logic [13:0] a2_7_q, a2_8_q;
  logic [16:0] a3d6;
  logic [2:0]  q8_q;
  logic [31:0] gsum;
  logic [gpa_pkg::G_W-1:0] g_q [9:22];

  // stage 5
  assign esum = 30'(ex_i) + 30'(ey_i);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      a5_q   <= esum[28:7];
      big5_q <= (esum >= 30'(gpa_pkg::E_LIMIT));
    end
  end

  // stage 6
  assign aa_d = 44'(a5_q) * 44'(a5_q);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      aa6_q  <= aa_d;
      a6_q   <= a5_q;
      big6_q <= big5_q;
    end
  end

  // stage 7
  assign a2a_d = 36'(aa6_q[43:30]) * 36'(a6_q);

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      a2_7_q <= aa6_q[43:30];
      a2a7_q <= a2a_d;
      a7_q   <= a6_q;
      big7_q <= big6_q;
    end
  end

  // stage 8
  assign a3d6 = gpa_pkg::div6(17'(a2a7_q[35:30]));

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      q8_q   <= a3d6[2:0];
      a2_8_q <= a2_7_q;
      a8_q   <= a7_q;
      big8_q <= big7_q;
    end
  end

  // stage 9: 1 - a + a^2/2 - a^3/6
  assign gsum = 32'(gpa_pkg::ONE_Q30) - 32'(a8_q) + 32'(a2_8_q[13:1]) - 32'(q8_q);

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      g_q[9] <= big8_q ? '0 : gsum[30:0];
    end
  end

  // stages 10..22: g = round(g^2)
  for (genvar k = 10; k <= 22; k++) begin : g_sq
    logic [61:0] sq;
    assign sq = 62'(g_q[k-1]) * 62'(g_q[k-1]) + 62'(1 << 29);
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        g_q[k] <= sq[60:30];
      end
    end
  end

  assign g_o = g_q[22];

endmodule

// File: rtl/gpa_carrier.sv
// Cosine carrier from quarter-wave table plus Taylor correction (stages 4 to 22).
// Uses gpa_pkg.
module gpa_carrier (
  input  logic                         clk_i,
  input  logic [gpa_pkg::NUM_STAGES:1] en_i,
  input  logic [23:0]                  phase_i,
  output logic signed [33:0]           car_o
);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  logic [22:0] rr;
  logic [4:0]  idx_d;
  logic signed [23:0] rem;
  logic [17:0] mag_d;

  quad_e       quad4_q, quad5_q, quad6_q, quad7_q, quad8_q, quad9_q, quad10_q;
  logic [4:0]  idx4_q, idx5_q, idx6_q, idx7_q, idx8_q;
  logic        neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic [17:0] mag4_q;
  logic [50:0] dmp;
  logic [25:0] dm5_q, dm6_q, dm7_q, dm8_q;
  logic [51:0] dd;
  logic [21:0] d2_6_q, d2_7_q, d2_8_q;
  logic [47:0] d3p;
  logic [43:0] d4p;
  logic [16:0] d3_7_q, d3q8_q;
  logic [12:0] d4_7_q, d4q8_q;
  logic signed [31:0] cd_d, cd9_q;
  logic [25:0] sm;
  logic signed [26:0] sd_d, sd9_q;
  logic [30:0] ct9_q, st9_q;
  logic signed [63:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [63:0] cdiff, ssum;
  logic signed [33:0] cc, ss, car_d;
  logic signed [33:0] car_q [11:22];

  // stage 4: table index and residual
  assign rr    = 23'(phase_i[21:0]) + 23'(1 << 17);
  assign idx_d = rr[22:18];
  assign rem   = $signed(24'(phase_i[21:0])) - $signed(24'({idx_d, 18'b0}));
  assign mag_d = rem[23] ? 18'(-rem) : 18'(rem);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      quad4_q <= quad_e'(phase_i[23:22]);
      idx4_q  <= idx_d;
      neg4_q  <= rem[23];
      mag4_q  <= mag_d;
    end
  end

  // stage 5: residual angle in radians, Q1.30
  assign dmp = 51'(mag4_q) * 51'(gpa_pkg::TWO_PI_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      dm5_q   <= dmp[49:24];
      quad5_q <= quad4_q;
      idx5_q  <= idx4_q;
      neg5_q  <= neg4_q;
    end
  end

  // stage 6
  assign dd = 52'(dm5_q) * 52'(dm5_q);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      d2_6_q  <= dd[51:30];
      dm6_q   <= dm5_q;
      quad6_q <= quad5_q;
      idx6_q  <= idx5_q;
      neg6_q  <= neg5_q;
    end
  end

  // stage 7
  assign d3p = 48'(d2_6_q) * 48'(dm6_q);
  assign d4p = 44'(d2_6_q) * 44'(d2_6_q);

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      d3_7_q  <= d3p[46:30];
      d4_7_q  <= d4p[42:30];
      d2_7_q  <= d2_6_q;
      dm7_q   <= dm6_q;
      quad7_q <= quad6_q;
      idx7_q  <= idx6_q;
      neg7_q  <= neg6_q;
    end
  end

  // stage 8
  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      d3q8_q  <= gpa_pkg::div6(d3_7_q);
      d4q8_q  <= gpa_pkg::div24(d4_7_q);
      d2_8_q  <= d2_7_q;
      dm8_q   <= dm7_q;
      quad8_q <= quad7_q;
      idx8_q  <= idx7_q;
      neg8_q  <= neg7_q;
    end
  end

  // stage 9: cos/sin of residual, table lookups
  assign cd_d = $signed(32'(gpa_pkg::ONE_Q30)) - $signed(32'(d2_8_q[21:1]))
              + $signed(32'(d4q8_q));
  assign sm   = dm8_q - 26'(d3q8_q);
  assign sd_d = neg8_q ? -$signed(27'(sm)) : $signed(27'(sm));

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      cd9_q   <= cd_d;
      sd9_q   <= sd_d;
      ct9_q   <= gpa_pkg::COS_TAB[idx8_q];
      st9_q   <= gpa_pkg::COS_TAB[5'(5'd16 - idx8_q)];
      quad9_q <= quad8_q;
    end
  end

  // stage 10: rotation products
  always_ff @(posedge clk_i) begin
    if (en_i[10]) begin
      p1_q     <= 64'($signed({1'b0, ct9_q})) * 64'(cd9_q);
      p2_q     <= 64'($signed({1'b0, st9_q})) * 64'(sd9_q);
      p3_q     <= 64'($signed({1'b0, st9_q})) * 64'(cd9_q);
      p4_q     <= 64'($signed({1'b0, ct9_q})) * 64'(sd9_q);
      quad10_q <= quad9_q;
    end
  end

  // stage 11: floor shift and quadrant fold
  assign cdiff = p1_q - p2_q;
  assign ssum  = p3_q + p4_q;
  assign cc    = cdiff[63:30];
  assign ss    = ssum[63:30];

  always_comb begin
    unique case (quad10_q)
      QUAD_0: car_d = cc;
      QUAD_1: car_d = -ss;
      QUAD_2: car_d = -cc;
      QUAD_3: car_d = ss;
      default: car_d = cc;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[11]) begin
      car_q[11] <= car_d;
    end
  end

  // stages 12..22: align with envelope
  for (genvar k = 12; k <= 22; k++) begin : car_dly
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        car_q[k] <= car_q[k-1];
      end
    end
  end

  assign car_o = car_q[22];

endmodule

// File: rtl/gpa_mix.sv
// Envelope times carrier, amplitude scaling and saturating add (stages 23 to 25).
// Uses gpa_pkg.
module gpa_mix (
  input  logic                         clk_i,
  input  logic [gpa_pkg::NUM_STAGES:1] en_i,
  input  logic signed [31:0]           amplitude_i,
  input  logic [gpa_pkg::G_W-1:0]      g_i,
  input  logic signed [33:0]           car_i,
  input  logic signed [31:0]           pixel_i,
  output logic signed [31:0]           pixel_out_o,
  output logic                         saturated_o
);

  localparam logic signed [36:0] SumMax = 37'sd2147483647;
  localparam logic signed [36:0] SumMin = -37'sd2147483648;

  logic signed [65:0] gcp, tp;
  logic signed [33:0] gc_q;
  logic signed [35:0] term_q;
  logic signed [36:0] sum;
  logic signed [31:0] pix_q;
  logic               sat_q;

  assign gcp = 66'($signed({1'b0, g_i})) * 66'(car_i);

  always_ff @(posedge clk_i) begin
    if (en_i[23]) begin
      gc_q <= gcp[63:30];
    end
  end

  assign tp = 66'(amplitude_i) * 66'(gc_q) + 66'(1 << 29);

  always_ff @(posedge clk_i) begin
    if (en_i[24]) begin
      term_q <= tp[65:30];
    end
  end

  assign sum = 37'(pixel_i) + 37'(term_q);

  always_ff @(posedge clk_i) begin
    if (en_i[25]) begin
      if (sum > SumMax) begin
        pix_q <= SumMax[31:0];
        sat_q <= 1'b1;
      end else if (sum < SumMin) begin
        pix_q <= SumMin[31:0];
        sat_q <= 1'b1;
      end else begin
        pix_q <= sum[31:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign pixel_out_o = pix_q;
  assign saturated_o = sat_q;

endmodule

// File: rtl/gabor_patch_adder_unit.sv
// Top level of the Gabor patch adder: config registers, pipeline control, pixel delay.
// Uses gpa_pkg, gpa_geom, gpa_env, gpa_carrier, gpa_mix, gabor_patch_adder_unit_defines.svh.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: pixel_in, column, row
// m_axis    out  tvalid/tready           tdata: pixel_out; tuser: saturated
// cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle through 25 register stages unless the output stalls with all
// stages full. The deepest part is the 13-stage squaring chain of the envelope.
// Reset clears valid bits and config registers only; no clearing pass.
// Each stage holds when the next one is full and stalled; bubbles close up,
// so input is taken while the output register waits unless all stages are full.
`include "gabor_patch_adder_unit_defines.svh"

module gabor_patch_adder_unit #(
  parameter int unsigned MaxCols = gpa_pkg::MAX_COLS,
  parameter int unsigned MaxRows = gpa_pkg::MAX_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [31:0] pixel_in, [43:32] column, [55:44] row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pixel_out
  output logic [0:0]  m_axis_tuser,   // [0] saturated
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned NS = gpa_pkg::NUM_STAGES;

  gpa_pkg::cfg_t cfg_q;
  logic [NS:1] v_q, v_in, en;
  logic signed [31:0] pix_q [1:24];
  logic [gpa_pkg::E_W-1:0] ex, ey;
  logic [23:0] phase;
  logic [gpa_pkg::G_W-1:0] g;
  logic signed [33:0] car;
  logic signed [31:0] pixel_out;
  logic saturated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (gpa_pkg::cfg_reg_e'(cfg_idx_i))
        gpa_pkg::CFG_X_CENTER:  cfg_q.x_center       <= cfg_wdata_i[19:0];
        gpa_pkg::CFG_Y_CENTER:  cfg_q.y_center       <= cfg_wdata_i[19:0];
        gpa_pkg::CFG_X_STEP:    cfg_q.x_phase_step   <= cfg_wdata_i[23:0];
        gpa_pkg::CFG_Y_STEP:    cfg_q.y_phase_step   <= cfg_wdata_i[23:0];
        gpa_pkg::CFG_X_SPREAD:  cfg_q.x_spread_coeff <= cfg_wdata_i;
        gpa_pkg::CFG_Y_SPREAD:  cfg_q.y_spread_coeff <= cfg_wdata_i;
        gpa_pkg::CFG_PHASE_OFS: cfg_q.phase_offset   <= cfg_wdata_i[23:0];
        gpa_pkg::CFG_AMPLITUDE: cfg_q.amplitude      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage k may load when some stage at or after it is empty, or output drains
  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = m_axis_tready || !(&v_q[NS:k]);
  end

  assign v_in = {v_q[NS-1:1], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) pix_q[1] <= s_axis_tdata[31:0];
  end

  for (genvar k = 2; k <= 24; k++) begin : g_pix
    always_ff @(posedge clk_i) begin
      if (en[k]) pix_q[k] <= pix_q[k-1];
    end
  end

  gpa_geom #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_geom (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .col_i   (s_axis_tdata[43:32]),
    .row_i   (s_axis_tdata[55:44]),
    .ex_o    (ex),
    .ey_o    (ey),
    .phase_o (phase)
  );

  gpa_env u_env (
    .clk_i (clk_i),
    .en_i  (en),
    .ex_i  (ex),
    .ey_i  (ey),
    .g_o   (g)
  );

  gpa_carrier u_carrier (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (phase),
    .car_o   (car)
  );

  gpa_mix u_mix (
    .clk_i       (clk_i),
    .en_i        (en),
    .amplitude_i (cfg_q.amplitude),
    .g_i         (g),
    .car_i       (car),
    .pixel_i     (pix_q[24]),
    .pixel_out_o (pixel_out),
    .saturated_o (saturated)
  );

  assign s_axis_tready   = en[1];
  assign m_axis_tvalid   = v_q[NS];
  assign m_axis_tdata    = pixel_out;
  assign m_axis_tuser[0] = saturated;

  `GPA_ASSERT(a_full_when_blocked, !s_axis_tready, (&v_q) && !m_axis_tready, "input blocked with a free stage")
  `GPA_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, v_q[1], "accepted transaction not in first stage")
  `GPA_ASSERT(a_sat_clip, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 32'h7FFFFFFF) || (m_axis_tdata == 32'h80000000), "saturated flag without clipped value")

endmodule

// File: test/gpa_checker.sv
// Checker for the Gabor patch adder: watches the config port and both streams,
// predicts each output pixel from its own register copy and compares in order.
// Depends on gpa_pkg for the register index codes.
`timescale 1ns / 1ps

module gpa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [55:0] s_tdata_i,   // [31:0] pixel_in, [43:32] column, [55:44] row
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [31:0] pixel_out
  input  logic [0:0]  m_tuser_i,   // [0] saturated
  input  logic        cfg_we_i,
  input  gpa_pkg::cfg_reg_e cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          errors_o,
  output int          pending_o
);
  import gpa_pkg::*;

  typedef struct packed {
    logic [31:0] pixel;
    logic        sat;
  } pixel_result_t;

  localparam longint EXP_CAP   = longint'(24) << 24;
  localparam longint UNIT_Q30  = longint'(1) << 30;
  localparam longint HALF_Q30  = longint'(1) << 29;
  localparam longint TURN_Q30  = 64'sd6746518852;
  localparam longint COS_PPB [17] = '{
    1000000000, 995184727, 980785280, 956940336, 923879533, 881921264,
    831469612, 773010453, 707106781, 634393284, 555570233, 471396737,
    382683432, 290284677, 195090322, 98017140, 0
  };

  logic signed [19:0] x_mean, y_mean;
  logic signed [23:0] x_step, y_step;
  logic        [31:0] x_spread, y_spread;
  logic        [23:0] phase_base;
  logic signed [31:0] gain;

  pixel_result_t expected_pixels[$];

  function automatic longint spread_exponent(longint k, longint dist_sq);
    longint hi, e;
    hi = (k >> 16) * dist_sq;
    if (hi >= (EXP_CAP >> 8)) return EXP_CAP;
    e = (hi << 8) + (((k & 64'hFFFF) * dist_sq) >> 8);
    return (e > EXP_CAP) ? EXP_CAP : e;
  endfunction

  function automatic longint gauss_q30(longint e);
    longint a, a2, a3, g;
    if (e >= EXP_CAP) return 0;
    a  = e >> 7;
    a2 = (a * a) >> 30;
    a3 = (a2 * a) >> 30;
    g  = UNIT_Q30 - a + (a2 >> 1) - a3 / 6;
    for (int i = 0; i < 13; i++) g = (g * g + HALF_Q30) >> 30;
    return g;
  endfunction

  function automatic longint cos_q30(int k);
    return (COS_PPB[k] * UNIT_Q30 + 500000000) / 1000000000;
  endfunction

  function automatic longint wave_q30(logic [23:0] p);
    longint r, rem, mag, dm, d2, d3, d4, cd, sm, sd, ct, st, c, s;
    int idx;
    r   = longint'(p[21:0]);
    idx = int'((r + 131072) >> 18);
    rem = r - (longint'(idx) << 18);
    mag = (rem < 0) ? -rem : rem;
    dm  = (mag * TURN_Q30) >> 24;
    d2  = (dm * dm) >> 30;
    d3  = (d2 * dm) >> 30;
    d4  = (d2 * d2) >> 30;
    cd  = UNIT_Q30 - (d2 >> 1) + d4 / 24;
    sm  = dm - d3 / 6;
    sd  = (rem < 0) ? -sm : sm;
    ct  = cos_q30(idx);
    st  = cos_q30(16 - idx);
    c   = (ct * cd - st * sd) >>> 30;
    s   = (st * cd + ct * sd) >>> 30;
    case (p[23:22])
      2'd0: return c;
      2'd1: return -s;
      2'd2: return -c;
      default: return s;
    endcase
  endfunction

  function automatic pixel_result_t add_patch(logic [55:0] beat);
    pixel_result_t res;
    longint dx, dy, e, g, ph, gc, term, sum;
    logic [63:0] ph_bits;
    dx = longint'(beat[43:32]) * 16 - longint'(x_mean);
    dy = longint'(beat[55:44]) * 16 - longint'(y_mean);
    e  = spread_exponent(longint'(x_spread), dx * dx) +
         spread_exponent(longint'(y_spread), dy * dy);
    if (e > EXP_CAP) e = EXP_CAP;
    g  = gauss_q30(e);
    ph = (longint'(phase_base) << 4) + longint'(x_step) * dx + longint'(y_step) * dy;
    ph_bits = ph;
    gc   = (g * wave_q30(ph_bits[27:4])) >>> 30;
    term = (longint'(gain) * gc + HALF_Q30) >>> 30;
    sum  = longint'($signed(beat[31:0])) + term;
    res.sat = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      res.sat = 1'b1;
    end
    if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.pixel = sum[31:0];
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_mean <= '0; y_mean <= '0; x_step <= '0; y_step <= '0;
      x_spread <= '0; y_spread <= '0; phase_base <= '0; gain <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_CENTER:  x_mean     <= cfg_wdata_i[19:0];
        CFG_Y_CENTER:  y_mean     <= cfg_wdata_i[19:0];
        CFG_X_STEP:    x_step     <= cfg_wdata_i[23:0];
        CFG_Y_STEP:    y_step     <= cfg_wdata_i[23:0];
        CFG_X_SPREAD:  x_spread   <= cfg_wdata_i;
        CFG_Y_SPREAD:  y_spread   <= cfg_wdata_i;
        CFG_PHASE_OFS: phase_base <= cfg_wdata_i[23:0];
        CFG_AMPLITUDE: gain       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) expected_pixels.push_back(add_patch(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output transaction %h", m_tdata_i);
          errors_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata_i !== want.pixel) begin
            $error("pixel_out expected %h actual %h", want.pixel, m_tdata_i);
            errors_o++;
          end
          if (m_tuser_i[0] !== want.sat) begin
            $error("saturated expected %b actual %b", want.sat, m_tuser_i[0]);
            errors_o++;
          end
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for gabor_patch_adder_unit: clock, reset, config phases, pixel
// stimulus with random idling, watchdog and verdict. Uses gpa_checker and gpa_pkg.
`timescale 1ns / 1ps

module tb_top;
  import gpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i;
  cfg_reg_e    cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  int          errors, pending, stuck_cycles;
  bit          quiet, gaps_on, holdoff_req;
  int          mid_col, mid_row;

  gabor_patch_adder_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  gpa_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side: random stalls, one long holdoff on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (holdoff_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        holdoff_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic send_pixel(logic [31:0] pix, int col, int row);
    if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {12'(row), 12'(col), pix};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic load_config(logic [31:0] xc, logic [31:0] yc, logic [31:0] xs,
                             logic [31:0] ys, logic [31:0] kx, logic [31:0] ky,
                             logic [31:0] ph, logic [31:0] amp);
    logic [31:0] vals [8];
    vals = '{xc, yc, xs, ys, kx, ky, ph, amp};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_reg_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    mid_col = $signed(xc[19:0]) / 16;
    mid_row = $signed(yc[19:0]) / 16;
  endtask

  function automatic logic [31:0] pick_spread();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2000);
      1: return $urandom_range(0, 60000);
      2: return $urandom;
      default: return 32'd0;
    endcase
  endfunction

  function automatic int near(int mid);
    int v;
    v = mid + $urandom_range(0, 120) - 60;
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_X_CENTER; cfg_wdata_i = '0;
    quiet = 1'b0; gaps_on = 1'b0; holdoff_req = 1'b0;
    stuck_cycles = 0; mid_col = 0; mid_row = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: zero amplitude passes pixels through
    send_pixel(32'h7FFF_FFFF, 0, 0);
    send_pixel(32'h8000_0000, 4095, 4095);
    send_pixel(32'h0000_0000, 4095, 0);
    send_pixel(32'hFFFF_FFFF, 0, 4095);
    drain();

    // peak at frame center, extreme steps and phase offset, positive clipping
    load_config(32'd32768, 32'd32768, 32'h7F_FFFF, 32'h80_0000, 32'h1000, 32'h1000,
                32'hFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(32'h7FFF_FFFF, 2048, 2048);
    send_pixel(32'h8000_0000, 2048, 2048);
    send_pixel(32'h0000_0000, 2049, 2047);
    send_pixel(32'h1234_5678, 2060, 2030);
    send_pixel(32'h0000_0000, 0, 0);
    send_pixel(32'h7FFF_FFFF, 4095, 4095);
    drain();

    // flat envelope, carrier at half turn, negative clipping
    load_config(32'hF_FFFF & 32'h8_0000, 32'h7_FFFF, 32'd0, 32'd0, 32'd0, 32'd0,
                32'h80_0000, 32'h7FFF_FFFF);
    send_pixel(32'h8000_0000, 0, 4095);
    send_pixel(32'h8000_1000, 100, 100);
    send_pixel(32'h7FFF_FFFF, 4095, 0);
    drain();

    // steepest spread and most negative amplitude
    load_config(32'h7_FFFF, 32'h8_0000, 32'h80_0000, 32'h7F_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'd0, 32'h8000_0000);
    send_pixel(32'h0000_0000, 4095, 0);
    send_pixel(32'h7FFF_FFFF, 0, 4095);
    drain();
    load_config(32'd16, 32'd16, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
    send_pixel(32'h8000_0000, 1, 1);
    send_pixel(32'h7FFF_FFFF, 1, 1);
    send_pixel(32'h0000_0001, 3000, 12);
    drain();

    gaps_on = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      load_config($urandom_range(0, 65520), $urandom_range(0, 65520),
                  $urandom, $urandom, pick_spread(), pick_spread(),
                  $urandom, $urandom);
      if (ph == 2) holdoff_req = 1'b1;
      if (ph == 7) quiet = 1'b1;
      for (int n = 0; n < 172; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_pixel($urandom, $urandom_range(0, 4095), $urandom_range(0, 4095));
        else
          send_pixel($urandom, near(mid_col), near(mid_row));
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: gabor_patch_adder_unit.f
+incdir+rtl
rtl/gpa_pkg.sv
rtl/gpa_geom.sv
rtl/gpa_env.sv
rtl/gpa_carrier.sv
rtl/gpa_mix.sv
rtl/gabor_patch_adder_unit.sv
test/gpa_checker.sv
test/tb_top.sv
